/* src/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the RGB / HSV colour converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  typedef enum logic {
    OP_RGB2HSV = 1'b0,
    OP_HSV2RGB = 1'b1
  } op_t;

  localparam int unsigned DP_STAGES = 5;
  localparam int unsigned STAGES    = DP_STAGES + 1;
  localparam int unsigned IN_W      = 56;
  localparam int unsigned OUT_W     = 56;

  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_FULL   = 23040;
  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned HSV_DEN    = FULL_SCALE * HUE_SECTOR;

  // Reciprocal scaling shifts, chosen so that the truncated product is exact.
  localparam int unsigned RECIP_SHIFT = 31;
  localparam int unsigned P_SHIFT     = 25;
  localparam int unsigned DEN_SHIFT   = 49;

  localparam logic [17:0] RECIP_255 =
    18'(((64'd1 << P_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));
  localparam logic [29:0] RECIP_DEN =
    30'(((64'd1 << DEN_SHIFT) + 64'(HSV_DEN) - 64'd1) / 64'(HSV_DEN));

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

endpackage

/* src/rhc_rgb2hsv.sv */
// ----------------------------------------------------------------------------
// rhc_rgb2hsv
// Five-stage RGB to HSV datapath; divisions use a reciprocal table.
// ----------------------------------------------------------------------------
module rhc_rgb2hsv (
  input  logic                           clk,
  input  logic [rhc_pkg::DP_STAGES-1:0]  stage_en,
  input  rhc_pkg::rgb_t                  pix_in,
  output rhc_pkg::hsv_t                  hsv_out
);

  logic [31:0] recip_tbl [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_recip
    localparam longint unsigned RV = (gi == 0) ? 64'd0 :
      ((64'd1 << rhc_pkg::RECIP_SHIFT) + 64'(gi) - 64'd1) / 64'((gi == 0) ? 1 : gi);
    assign recip_tbl[gi] = 32'(RV);
  end

  logic [7:0]  mx, mn, delta;
  logic        rmax, gmax;
  logic [10:0] r11, g11, b11, d11, k;

  logic [10:0] k1_r;
  logic [7:0]  delta1_r, mx1_r;
  logic [22:0] num2_r;
  logic [15:0] satn2_r;
  logic [31:0] rd2_r, rm2_r;
  logic [7:0]  mx2_r;
  logic [54:0] hp3_r;
  logic [47:0] sp3_r;
  logic [7:0]  mx3_r;
  logic [14:0] hue4_r;
  logic [7:0]  sat4_r, mx4_r;
  logic [14:0] hue5_r;
  logic [7:0]  sat5_r, mx5_r;

  always_comb begin
    mx = pix_in.red;
    if (pix_in.green > mx) mx = pix_in.green;
    if (pix_in.blue > mx) mx = pix_in.blue;
    mn = pix_in.red;
    if (pix_in.green < mn) mn = pix_in.green;
    if (pix_in.blue < mn) mn = pix_in.blue;
    delta = mx - mn;
    rmax  = (pix_in.red == mx);
    gmax  = !rmax && (pix_in.green == mx);
    r11   = 11'(pix_in.red);
    g11   = 11'(pix_in.green);
    b11   = 11'(pix_in.blue);
    d11   = 11'(delta);
    // The hue numerator is the sector width times k; k always ends up non-negative.
    if (rmax) begin
      if (g11 >= b11) begin
        k = g11 - b11;
      end else begin
        k = d11 * 11'd6 - (b11 - g11);
      end
    end else if (gmax) begin
      k = (d11 << 1) + b11 - r11;
    end else begin
      k = (d11 << 2) + r11 - g11;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      k1_r     <= k;
      delta1_r <= delta;
      mx1_r    <= mx;
    end
    if (stage_en[1]) begin
      num2_r  <= 23'(k1_r) * 23'(rhc_pkg::HUE_SECTOR);
      satn2_r <= 16'(delta1_r) * 16'(rhc_pkg::FULL_SCALE);
      rd2_r   <= recip_tbl[delta1_r];
      rm2_r   <= recip_tbl[mx1_r];
      mx2_r   <= mx1_r;
    end
    if (stage_en[2]) begin
      hp3_r <= 55'(num2_r) * 55'(rd2_r);
      sp3_r <= 48'(satn2_r) * 48'(rm2_r);
      mx3_r <= mx2_r;
    end
    if (stage_en[3]) begin
      hue4_r <= hp3_r[rhc_pkg::RECIP_SHIFT +: 15];
      sat4_r <= sp3_r[rhc_pkg::RECIP_SHIFT +: 8];
      mx4_r  <= mx3_r;
    end
    if (stage_en[4]) begin
      hue5_r <= (hue4_r >= 15'(rhc_pkg::HUE_FULL)) ?
                hue4_r - 15'(rhc_pkg::HUE_FULL) : hue4_r;
      sat5_r <= sat4_r;
      mx5_r  <= mx4_r;
    end
  end

  assign hsv_out.hue = hue5_r;
  assign hsv_out.sat = sat5_r;
  assign hsv_out.val = mx5_r;

endmodule

/* src/rhc_hsv2rgb.sv */
// ----------------------------------------------------------------------------
// rhc_hsv2rgb
// Five-stage HSV to RGB datapath forming the p, q and t terms.
// ----------------------------------------------------------------------------
module rhc_hsv2rgb (
  input  logic                           clk,
  input  logic [rhc_pkg::DP_STAGES-1:0]  stage_en,
  input  rhc_pkg::hsv_t                  hsv_in,
  output rhc_pkg::rgb_t                  pix_out
);

  logic [14:0] hc, base;
  logic [2:0]  sec;

  logic [2:0]  sec1_r, sec2_r, sec3_r, sec4_r, sec5_r;
  logic        zero1_r, zero2_r, zero3_r, zero4_r, zero5_r;
  logic [7:0]  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [11:0] frac1_r;
  logic [7:0]  s1_r, sinv1_r;
  logic [19:0] sf2_r, sg2_r;
  logic [15:0] pn2_r;
  logic [19:0] qd3_r, td3_r;
  logic [33:0] pp3_r;
  logic [27:0] qn4_r, tn4_r;
  logic [7:0]  p4_r, p5_r;
  logic [57:0] qp5_r, tp5_r;
  logic [7:0]  q, t;

  always_comb begin
    hc = (hsv_in.hue >= 15'(rhc_pkg::HUE_FULL)) ? 15'd0 : hsv_in.hue;
    if (hc >= 15'(5 * rhc_pkg::HUE_SECTOR)) begin
      sec  = 3'd5;
      base = 15'(5 * rhc_pkg::HUE_SECTOR);
    end else if (hc >= 15'(4 * rhc_pkg::HUE_SECTOR)) begin
      sec  = 3'd4;
      base = 15'(4 * rhc_pkg::HUE_SECTOR);
    end else if (hc >= 15'(3 * rhc_pkg::HUE_SECTOR)) begin
      sec  = 3'd3;
      base = 15'(3 * rhc_pkg::HUE_SECTOR);
    end else if (hc >= 15'(2 * rhc_pkg::HUE_SECTOR)) begin
      sec  = 3'd2;
      base = 15'(2 * rhc_pkg::HUE_SECTOR);
    end else if (hc >= 15'(rhc_pkg::HUE_SECTOR)) begin
      sec  = 3'd1;
      base = 15'(rhc_pkg::HUE_SECTOR);
    end else begin
      sec  = 3'd0;
      base = 15'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sec1_r  <= sec;
      frac1_r <= 12'(hc - base);
      zero1_r <= (hsv_in.sat == 8'd0);
      s1_r    <= hsv_in.sat;
      sinv1_r <= 8'(rhc_pkg::FULL_SCALE) - hsv_in.sat;
      v1_r    <= hsv_in.val;
    end
    if (stage_en[1]) begin
      sf2_r   <= 20'(s1_r) * 20'(frac1_r);
      sg2_r   <= 20'(s1_r) * 20'(12'(rhc_pkg::HUE_SECTOR) - frac1_r);
      pn2_r   <= 16'(v1_r) * 16'(sinv1_r);
      sec2_r  <= sec1_r;
      zero2_r <= zero1_r;
      v2_r    <= v1_r;
    end
    if (stage_en[2]) begin
      qd3_r   <= 20'(rhc_pkg::HSV_DEN) - sf2_r;
      td3_r   <= 20'(rhc_pkg::HSV_DEN) - sg2_r;
      pp3_r   <= 34'(pn2_r) * 34'(rhc_pkg::RECIP_255);
      sec3_r  <= sec2_r;
      zero3_r <= zero2_r;
      v3_r    <= v2_r;
    end
    if (stage_en[3]) begin
      qn4_r   <= 28'(v3_r) * 28'(qd3_r);
      tn4_r   <= 28'(v3_r) * 28'(td3_r);
      p4_r    <= pp3_r[rhc_pkg::P_SHIFT +: 8];
      sec4_r  <= sec3_r;
      zero4_r <= zero3_r;
      v4_r    <= v3_r;
    end
    if (stage_en[4]) begin
      qp5_r   <= 58'(qn4_r) * 58'(rhc_pkg::RECIP_DEN);
      tp5_r   <= 58'(tn4_r) * 58'(rhc_pkg::RECIP_DEN);
      p5_r    <= p4_r;
      sec5_r  <= sec4_r;
      zero5_r <= zero4_r;
      v5_r    <= v4_r;
    end
  end

  assign q = qp5_r[rhc_pkg::DEN_SHIFT +: 8];
  assign t = tp5_r[rhc_pkg::DEN_SHIFT +: 8];

  always_comb begin
    if (zero5_r) begin
      pix_out = '{red: v5_r, green: v5_r, blue: v5_r};
    end else begin
      case (sec5_r)
        3'd0:    pix_out = '{red: v5_r, green: t,    blue: p5_r};
        3'd1:    pix_out = '{red: q,    green: v5_r, blue: p5_r};
        3'd2:    pix_out = '{red: p5_r, green: v5_r, blue: t};
        3'd3:    pix_out = '{red: p5_r, green: q,    blue: v5_r};
        3'd4:    pix_out = '{red: t,    green: p5_r, blue: v5_r};
        default: pix_out = '{red: v5_r, green: p5_r, blue: q};
      endcase
    end
  end

endmodule

/* src/rgb_hsv_color_converter_unit.sv */
// ----------------------------------------------------------------------------
// rgb_hsv_color_converter_unit
// Pixel colour converter between RGB and HSV, one item per clock while in_tready is high.
// ----------------------------------------------------------------------------
// An item enters on the in_ stream: in_tuser picks the direction (0 for RGB to
// HSV, 1 for HSV to RGB) and in_tdata carries both pixel forms; the unused one
// is ignored. Each item gives exactly one result item on the out_ stream, with
// the fields of the other direction set to zero.
// The datapath is six register stages deep, the last being the output
// register, and a result passes through every stage before it shows on
// out_tvalid. One item is taken in every cycle while in_tready is high; the
// rate is set by the multiplier stages, each of which holds one product per
// item. Every stage has its own valid bit and a stage moves on whenever the
// one after it is empty or moving, so bubbles are squeezed out and in_tready
// stays high while a result waits, until all stages are full.
// A synchronous active-low reset clears every valid bit; the stage data is
// not reset. When the receiver stalls, the output item holds steady and no
// item is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // red[7:0], green[15:8], blue[23:16], hue[38:24], sat[46:39], val[54:47], pad
  input  logic [rhc_pkg::IN_W-1:0]   in_tdata,
  // operation[0]
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // red[7:0], green[15:8], blue[23:16], hue[38:24], sat[46:39], val[54:47], pad
  output logic [rhc_pkg::OUT_W-1:0]  out_tdata
);

  logic [rhc_pkg::STAGES-1:0]    valid_r, valid_nxt;
  logic [rhc_pkg::STAGES-1:0]    stage_en;
  rhc_pkg::op_t                  op_r [rhc_pkg::DP_STAGES];
  rhc_pkg::rgb_t                 pix_in, pix_res;
  rhc_pkg::hsv_t                 hsv_in, hsv_res;
  logic [rhc_pkg::OUT_W-1:0]     out_data_r, out_data_nxt;

  assign pix_in = '{red: in_tdata[7:0], green: in_tdata[15:8], blue: in_tdata[23:16]};
  assign hsv_in = '{hue: in_tdata[38:24], sat: in_tdata[46:39], val: in_tdata[54:47]};

  always_comb begin
    stage_en[rhc_pkg::STAGES-1] = ~valid_r[rhc_pkg::STAGES-1] | out_tready;
    for (int i = rhc_pkg::STAGES - 2; i >= 0; i--) begin
      stage_en[i] = ~valid_r[i] | stage_en[i+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[0]) valid_nxt[0] = in_tvalid;
    for (int i = 1; i < rhc_pkg::STAGES; i++) begin
      if (stage_en[i]) valid_nxt[i] = valid_r[i-1];
    end
  end

  rhc_rgb2hsv u_rgb2hsv (
    .clk      (clk),
    .stage_en (stage_en[rhc_pkg::DP_STAGES-1:0]),
    .pix_in   (pix_in),
    .hsv_out  (hsv_res)
  );

  rhc_hsv2rgb u_hsv2rgb (
    .clk      (clk),
    .stage_en (stage_en[rhc_pkg::DP_STAGES-1:0]),
    .hsv_in   (hsv_in),
    .pix_out  (pix_res)
  );

  always_comb begin
    if (op_r[rhc_pkg::DP_STAGES-1] == rhc_pkg::OP_HSV2RGB) begin
      out_data_nxt = {1'b0, 31'd0, pix_res.blue, pix_res.green, pix_res.red};
    end else begin
      out_data_nxt = {1'b0, hsv_res.val, hsv_res.sat, hsv_res.hue, 24'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (stage_en[0]) op_r[0] <= rhc_pkg::op_t'(in_tuser);
    for (int i = 1; i < rhc_pkg::DP_STAGES; i++) begin
      if (stage_en[i]) op_r[i] <= op_r[i-1];
    end
    if (stage_en[rhc_pkg::STAGES-1]) out_data_r <= out_data_nxt;
  end

  assign in_tready  = stage_en[0];
  assign out_tvalid = valid_r[rhc_pkg::STAGES-1];
  assign out_tdata  = out_data_r;

endmodule

/* src/rhc_checker.sv */
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the colour converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [rhc_pkg::OUT_W-1:0]  out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused while the output is free");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:0] == 24'd0 || out_tdata[54:24] == 31'd0)
    else $error("result item carries fields of both directions");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[38:24] < 15'(rhc_pkg::HUE_FULL) && !out_tdata[55])
    else $error("hue out of range or padding set");

endmodule

bind rgb_hsv_color_converter_unit rhc_checker u_rhc_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB / HSV colour converter unit.
// ----------------------------------------------------------------------------
// A table of directed pixels covers the channel extremes, grey, ties for the
// largest channel, the sector boundaries, zero saturation and hue codes past a
// full turn. A long run of random pixels follows. Each accepted item's expected
// result comes from the table or from a predictor in the bench, and every result
// item is compared field by field with the oldest prediction. Both streams idle
// at random, and the receiver holds off once, long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DIRECTED_ROWS   = 24;
  localparam int unsigned RANDOM_ITEMS    = 1426;
  localparam int unsigned IDLE_PERCENT    = 18;
  localparam int unsigned TX_STEADY_FIRST = 800;
  localparam int unsigned TX_STEADY_LAST  = 1100;
  localparam int unsigned RX_STEADY_FIRST = 800;
  localparam int unsigned RX_STEADY_LAST  = 1100;
  localparam int unsigned HOLD_AT         = 200;
  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PREDICT_DEPTH   = 64;

  localparam int unsigned SECTOR_UNITS = 3840;
  localparam int unsigned TURN_UNITS   = 23040;
  localparam int unsigned LEVEL_MAX    = 255;

  typedef struct packed {
    rhc_pkg::op_t op;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic [14:0]  hue;
    logic [7:0]   sat;
    logic [7:0]   val;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } colour_t;

  typedef struct {
    rhc_pkg::op_t op;
    int unsigned  red, green, blue, hue, sat, val;
    bit           typed;
    colour_t      want;
  } pixel_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [rhc_pkg::IN_W-1:0]  in_tdata;
  logic                      in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [rhc_pkg::OUT_W-1:0] out_tdata;

  colour_t             predictions [PREDICT_DEPTH];
  int unsigned         predict_wr = 0;
  int unsigned         predict_rd = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;

  pixel_row_t directed_rows [DIRECTED_ROWS] = '{
    '{rhc_pkg::OP_RGB2HSV,   0,   0,   0,     0,   0,   0, 1'b1, '{0, 0, 0,     0,   0,   0}},
    '{rhc_pkg::OP_RGB2HSV, 255, 255, 255,     0,   0,   0, 1'b1, '{0, 0, 0,     0,   0, 255}},
    '{rhc_pkg::OP_RGB2HSV, 255,   0,   0,     0,   0,   0, 1'b1, '{0, 0, 0,     0, 255, 255}},
    '{rhc_pkg::OP_RGB2HSV,   0, 255,   0,     0,   0,   0, 1'b1, '{0, 0, 0,  7680, 255, 255}},
    '{rhc_pkg::OP_RGB2HSV,   0,   0, 255,     0,   0,   0, 1'b1, '{0, 0, 0, 15360, 255, 255}},
    '{rhc_pkg::OP_RGB2HSV, 255, 255,   0,     0,   0,   0, 1'b1, '{0, 0, 0,  3840, 255, 255}},
    '{rhc_pkg::OP_RGB2HSV,   0, 255, 255,     0,   0,   0, 1'b1, '{0, 0, 0, 11520, 255, 255}},
    '{rhc_pkg::OP_RGB2HSV, 255,   0, 255,     0,   0,   0, 1'b1, '{0, 0, 0, 19200, 255, 255}},
    '{rhc_pkg::OP_RGB2HSV, 128, 128, 128,     0,   0,   0, 1'b1, '{0, 0, 0,     0,   0, 128}},
    '{rhc_pkg::OP_RGB2HSV, 255,   0,   1,     0,   0,   0, 1'b0, '{0, 0, 0,     0,   0,   0}},
    '{rhc_pkg::OP_RGB2HSV,   1,   0,   0,     0,   0,   0, 1'b1, '{0, 0, 0,     0, 255,   1}},
    '{rhc_pkg::OP_RGB2HSV,  10,  20,  30, 32767, 255, 255, 1'b0, '{0, 0, 0,     0,   0,   0}},
    '{rhc_pkg::OP_RGB2HSV, 254, 255, 253,     0,   0,   0, 1'b0, '{0, 0, 0,     0,   0,   0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0, 12345,   0, 200, 1'b1, '{200, 200, 200, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0,     0, 255, 255, 1'b1, '{255,   0,   0, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0, 23040, 255, 255, 1'b1, '{255,   0,   0, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0, 32767, 255, 255, 1'b1, '{255,   0,   0, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0, 23039, 255, 255, 1'b0, '{0, 0, 0,     0,   0,   0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0,  7680, 255, 255, 1'b1, '{  0, 255,   0, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0, 15360, 255, 255, 1'b1, '{  0,   0, 255, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0, 19200, 255, 255, 1'b1, '{255,   0, 255, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0,  5000, 255,   0, 1'b1, '{  0,   0,   0, 0, 0, 0}},
    '{rhc_pkg::OP_HSV2RGB,   0,   0,   0,  3839, 128, 255, 1'b0, '{0, 0, 0,     0,   0,   0}},
    '{rhc_pkg::OP_HSV2RGB, 255, 255, 255,  1000, 100,  50, 1'b0, '{0, 0, 0,     0,   0,   0}}
  };

  rgb_hsv_color_converter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic colour_t convert_pixel(pixel_t px);
    colour_t     res;
    int unsigned r, g, b, hi, lo, spread, num, hue_val;
    int unsigned s, v, sector, frac, den, p, q, t;
    res = '0;
    if (px.op == rhc_pkg::OP_RGB2HSV) begin
      r = 32'(px.red);
      g = 32'(px.green);
      b = 32'(px.blue);
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      spread = hi - lo;
      res.val = 8'(hi);
      if (spread != 0) begin
        res.sat = 8'((spread * LEVEL_MAX) / hi);
        if (r == hi) begin
          if (g >= b) num = SECTOR_UNITS * (g - b);
          else num = TURN_UNITS * spread - SECTOR_UNITS * (b - g);
        end else if (g == hi) begin
          num = 2 * SECTOR_UNITS * spread + SECTOR_UNITS * b - SECTOR_UNITS * r;
        end else begin
          num = 4 * SECTOR_UNITS * spread + SECTOR_UNITS * r - SECTOR_UNITS * g;
        end
        hue_val = num / spread;
        if (hue_val >= TURN_UNITS) hue_val -= TURN_UNITS;
        res.hue = 15'(hue_val);
      end
    end else begin
      s = 32'(px.sat);
      v = 32'(px.val);
      hue_val = 32'(px.hue);
      if (s == 0) begin
        res.red = px.val;
        res.green = px.val;
        res.blue = px.val;
      end else begin
        if (hue_val >= TURN_UNITS) hue_val = 0;
        sector = hue_val / SECTOR_UNITS;
        frac = hue_val % SECTOR_UNITS;
        den = LEVEL_MAX * SECTOR_UNITS;
        p = (v * (LEVEL_MAX - s)) / LEVEL_MAX;
        q = (v * (den - s * frac)) / den;
        t = (v * (den - s * (SECTOR_UNITS - frac))) / den;
        case (sector)
          0: begin r = v; g = t; b = p; end
          1: begin r = q; g = v; b = p; end
          2: begin r = p; g = v; b = t; end
          3: begin r = p; g = q; b = v; end
          4: begin r = t; g = p; b = v; end
          default: begin r = v; g = p; b = q; end
        endcase
        res.red = 8'(r);
        res.green = 8'(g);
        res.blue = 8'(b);
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.op = rhc_pkg::op_t'($urandom_range(0, 1));
    px.red = random_level();
    px.green = random_level();
    px.blue = random_level();
    case ($urandom_range(0, 5))
      0: begin
        px.green = px.red;
        px.blue = px.red;
      end
      1: px.green = px.red;
      2: px.blue = px.green;
      3: px.blue = px.red;
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: px.hue = 15'($urandom);
      1: px.hue = 15'($urandom_range(0, 6) * SECTOR_UNITS);
      default: px.hue = 15'($urandom_range(0, TURN_UNITS - 1));
    endcase
    px.sat = random_level();
    px.val = random_level();
    return px;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : pixel_source
    pixel_t      px;
    colour_t     want;
    int unsigned n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (n = 0; n < DIRECTED_ROWS + RANDOM_ITEMS; n++) begin
      if (n < DIRECTED_ROWS) begin
        px.op = directed_rows[n].op;
        px.red = 8'(directed_rows[n].red);
        px.green = 8'(directed_rows[n].green);
        px.blue = 8'(directed_rows[n].blue);
        px.hue = 15'(directed_rows[n].hue);
        px.sat = 8'(directed_rows[n].sat);
        px.val = 8'(directed_rows[n].val);
        want = directed_rows[n].typed ? directed_rows[n].want : convert_pixel(px);
      end else begin
        px = random_pixel();
        want = convert_pixel(px);
      end
      while ((n < TX_STEADY_FIRST || n >= TX_STEADY_LAST) &&
             $urandom_range(0, 99) < IDLE_PERCENT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser <= px.op;
      in_tdata <= {1'b0, px.val, px.sat, px.hue, px.blue, px.green, px.red};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      predictions[predict_wr[5:0]] = want;
      predict_wr++;
    end
    in_tvalid <= 1'b0;
    while (predict_wr != predict_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned taken;
    int unsigned hold_left;
    bit          held;
    out_tready = 1'b0;
    taken = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) taken++;
      if (!held && taken == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if ((taken < RX_STEADY_FIRST || taken >= RX_STEADY_LAST) &&
                   $urandom_range(0, 99) < IDLE_PERCENT) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    colour_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predict_wr == predict_rd) begin
        $error("result item arrived with no prediction waiting");
        mismatch_count++;
      end else begin
        want = predictions[predict_rd[5:0]];
        predict_rd++;
        check_field("red_out", 32'(want.red), 32'(out_tdata[7:0]));
        check_field("green_out", 32'(want.green), 32'(out_tdata[15:8]));
        check_field("blue_out", 32'(want.blue), 32'(out_tdata[23:16]));
        check_field("hue_out", 32'(want.hue), 32'(out_tdata[38:24]));
        check_field("sat_out", 32'(want.sat), 32'(out_tdata[46:39]));
        check_field("val_out", 32'(want.val), 32'(out_tdata[54:47]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

/* filelist.f */
src/rhc_pkg.sv
src/rhc_rgb2hsv.sv
src/rhc_hsv2rgb.sv
src/rgb_hsv_color_converter_unit.sv
src/rhc_checker.sv
sim/testbench.sv
